[src/tdmas_pkg.sv]
`default_nettype none

package tdmas_pkg;

    // default timer width and widths fixed by the item fields
    localparam int TIME_BITS_DEF = 32;
    localparam int TICK_BITS     = 32;
    localparam int SLOT_BITS     = 5;
    localparam int NSLOT_BITS    = 4;
    localparam int CFG_IDX_BITS  = 3;
    localparam int STATUS_BITS   = 3;
    // slot number times slot length
    localparam int PROD_BITS     = SLOT_BITS + TICK_BITS;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_NODE_SLOT    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NUM_SLOTS    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SLOT_TICKS   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GUARD_TICKS  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PERIOD_TICKS = 3'd4;

    // register reset values
    localparam logic [SLOT_BITS-1:0]  RST_NODE_SLOT    = 5'd1;
    localparam logic [NSLOT_BITS-1:0] RST_NUM_SLOTS    = 4'd3;
    localparam logic [TICK_BITS-1:0]  RST_SLOT_TICKS   = 32'd10922;
    localparam logic [TICK_BITS-1:0]  RST_GUARD_TICKS  = 32'd2730;
    localparam logic [TICK_BITS-1:0]  RST_PERIOD_TICKS = 32'd32768;

    // result status codes
    localparam logic [STATUS_BITS-1:0] ST_LATCHED     = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_IGNORED     = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_NO_BEACON   = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_BEACON_NODE = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_SEND_NOW    = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_SEND_DELAY  = 3'd5;

    typedef struct packed {
        logic                 mode;
        logic [TICK_BITS-1:0] now;
    } evt_item_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [TICK_BITS-1:0]   delay;
    } res_item_t;

endpackage

`default_nettype wire

[src/tdmas_div.sv]
`default_nettype none

module tdmas_div
    import tdmas_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [TIME_BITS-1:0] dividend,
    input  wire logic [TICK_BITS-1:0] divisor,
    output logic                      done,
    output logic [TICK_BITS-1:0]      rem
);

    localparam int CNT_BITS = $clog2(TIME_BITS + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [TIME_BITS-1:0] num_reg, num_next;
    logic [TICK_BITS-1:0] rem_reg, rem_next;
    logic [TICK_BITS-1:0] div_reg, div_next;

    logic [TICK_BITS:0]   trial;
    logic [TICK_BITS+1:0] diff;

    // one restoring step: shift in next dividend bit, subtract if it fits
    assign trial = {rem_reg, num_reg[TIME_BITS-1]};
    assign diff  = {1'b0, trial} - {2'b00, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(TIME_BITS);
            num_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = diff[TICK_BITS+1] ? trial[TICK_BITS-1:0] : diff[TICK_BITS-1:0];
            num_next = num_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

[src/tdma_slot_transmit_scheduler_top.sv]
// tdma slot transmit scheduler with guard period
//
// evt channel (evt_valid / evt_stall / evt): one timestamped event per transfer,
// mode 0 = beacon received, mode 1 = send request; now is the timer value.
// res channel (res_valid / res_stall / res): exactly one result per event,
// status code plus delay in ticks (delay is zero unless status is send after delay).
// cfg port: cfg_we writes cfg_data into register cfg_index (node slot, number of
// slots, slot length, guard length, period length); indexes beyond the list are dropped.
//
// beacons, refused requests and beacon node requests pass only the decide and output
// states. a scheduled send request also passes the slot product, limit and evaluate
// states, and the divide state when the origin must be folded forward by whole periods:
// that fold is a remainder taken one bit per cycle on a restoring divider. one event is
// in work at a time; evt_stall is high from the transfer until the result is loaded into
// the output register, which frees the sequencer: while res_stall holds a result, the
// next event may still be taken, and its result waits until the register empties.
// reset clears the beacon flag and the origin and restores register defaults.
`default_nettype none

module tdma_slot_transmit_scheduler_top
    import tdmas_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    evt_valid,
    output logic                         evt_stall,
    input  wire evt_item_t               evt,
    output logic                         res_valid,
    input  wire logic                    res_stall,
    output res_item_t                    res,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [TICK_BITS-1:0]    cfg_data
);

    // compare width covers both the timer and slot products
    localparam int CW = ((TIME_BITS > PROD_BITS) ? TIME_BITS : PROD_BITS) + 1;
    // delay bits that survive the timer wrap and the 32 bit field
    localparam int OW = (TIME_BITS < TICK_BITS) ? TIME_BITS : TICK_BITS;

    // sequencer codes
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_LIM    = 3'd4;
    localparam logic [2:0] S_EVAL   = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    // configuration registers
    logic [SLOT_BITS-1:0]  node_slot_reg;
    logic [NSLOT_BITS-1:0] num_slots_reg;
    logic [TICK_BITS-1:0]  slot_ticks_reg;
    logic [TICK_BITS-1:0]  guard_ticks_reg;
    logic [TICK_BITS-1:0]  period_ticks_reg;

    // sequencer and scheduling state
    logic [2:0]             state_reg, state_next;
    logic                   seen_reg, seen_next;
    logic [TIME_BITS-1:0]   origin_reg, origin_next;
    logic                   mode_reg, mode_next;
    logic [TIME_BITS-1:0]   now_reg, now_next;
    logic [TIME_BITS-1:0]   d_reg, d_next;
    logic [PROD_BITS-1:0]   start_reg, start_next;
    logic [PROD_BITS-1:0]   limit_reg, limit_next;
    logic [STATUS_BITS-1:0] status_reg, status_next;
    logic [TICK_BITS-1:0]   delay_reg, delay_next;

    // output register
    logic      res_valid_reg, res_valid_next;
    res_item_t res_reg, res_next;

    // derived values
    logic                   evt_xfer;
    logic [63:0]            now_wide;
    logic [TIME_BITS-1:0]   d_now;
    logic [TICK_BITS-1:0]   per_t;
    logic [TICK_BITS-1:0]   slot_t;
    logic [SLOT_BITS-1:0]   sid;
    logic [SLOT_BITS-1:0]   s_idx;
    logic                   beacon_node;
    logic [PROD_BITS-1:0]   end_v;
    logic [PROD_BITS-1:0]   guard_x;
    logic [CW-1:0]          d_x, per_x, start_x, limit_x, d_now_x;
    logic [CW-1:0]          wait_same, wait_next;

    // divider link
    logic                   div_start;
    logic                   div_done;
    logic [TICK_BITS-1:0]   div_rem;
    logic [63:0]            rem_wide;
    logic [TIME_BITS-1:0]   rem_t;

    assign evt_stall = (state_reg != S_IDLE);
    assign evt_xfer  = evt_valid && !evt_stall;

    // timer value kept at the timer width
    assign now_wide = 64'(evt.now);
    assign rem_wide = 64'(div_rem);
    assign rem_t    = rem_wide[TIME_BITS-1:0];

    // zero lengths and slot zero behave as one
    assign per_t  = (period_ticks_reg == '0) ? TICK_BITS'(1) : period_ticks_reg;
    assign slot_t = (slot_ticks_reg == '0) ? TICK_BITS'(1) : slot_ticks_reg;
    assign sid    = (node_slot_reg == '0) ? SLOT_BITS'(1) : node_slot_reg;
    assign s_idx  = sid - SLOT_BITS'(1);

    assign beacon_node = (node_slot_reg == ({1'b0, num_slots_reg} + SLOT_BITS'(1)));

    // elapsed time since origin, wrapping at the timer width
    assign d_now   = now_reg - origin_reg;
    assign d_now_x = CW'(d_now);
    assign per_x   = CW'(per_t);

    // slot end and the guard length at the product width
    assign end_v   = start_reg + PROD_BITS'(slot_t);
    assign guard_x = PROD_BITS'(guard_ticks_reg);

    assign d_x       = CW'(d_reg);
    assign start_x   = CW'(start_reg);
    assign limit_x   = CW'(limit_reg);
    assign wait_same = start_x - d_x;
    assign wait_next = per_x - d_x + start_x;

    tdmas_div #(
        .TIME_BITS (TIME_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (d_now),
        .divisor  (per_t),
        .done     (div_done),
        .rem      (div_rem)
    );

    always_comb
    begin
        state_next     = state_reg;
        seen_next      = seen_reg;
        origin_next    = origin_reg;
        mode_next      = mode_reg;
        now_next       = now_reg;
        d_next         = d_reg;
        start_next     = start_reg;
        limit_next     = limit_reg;
        status_next    = status_reg;
        delay_next     = delay_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        div_start      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (evt_xfer)
                begin
                    mode_next  = evt.mode;
                    now_next   = now_wide[TIME_BITS-1:0];
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                delay_next = '0;
                state_next = S_OUT;
                if (!mode_reg)
                begin
                    // only the first beacon sets the origin
                    if (!seen_reg)
                    begin
                        origin_next = now_reg;
                        seen_next   = 1'b1;
                        status_next = ST_LATCHED;
                    end
                    else
                    begin
                        status_next = ST_IGNORED;
                    end
                end
                else if (beacon_node)
                begin
                    status_next = ST_BEACON_NODE;
                end
                else if (!seen_reg)
                begin
                    status_next = ST_NO_BEACON;
                end
                else
                begin
                    d_next = d_now;
                    if (d_now_x > per_x)
                    begin
                        // kick the divider with the elapsed time
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_DIV:
            begin
                // wait for the remainder
                if (div_done)
                begin
                    // origin + whole periods equals now minus the remainder
                    d_next      = rem_t;
                    origin_next = now_reg - rem_t;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                start_next = {{(PROD_BITS-SLOT_BITS){1'b0}}, s_idx}
                             * {{SLOT_BITS{1'b0}}, slot_t};
                state_next = S_LIM;
            end
            S_LIM:
            begin
                limit_next = (end_v > guard_x) ? (end_v - guard_x) : '0;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_OUT;
                if (d_x < start_x)
                begin
                    // slot still ahead in this period
                    status_next = ST_SEND_DELAY;
                    delay_next  = TICK_BITS'(wait_same[OW-1:0]);
                end
                else if (d_x < limit_x)
                begin
                    status_next = ST_SEND_NOW;
                    delay_next  = '0;
                end
                else
                begin
                    // slot passed or inside guard: wait for next period
                    status_next = ST_SEND_DELAY;
                    delay_next  = TICK_BITS'(wait_next[OW-1:0]);
                end
            end
            S_OUT:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_next.status = status_reg;
                    res_next.delay  = delay_reg;
                    res_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            seen_reg         <= 1'b0;
            origin_reg       <= '0;
            res_valid_reg    <= 1'b0;
            node_slot_reg    <= RST_NODE_SLOT;
            num_slots_reg    <= RST_NUM_SLOTS;
            slot_ticks_reg   <= RST_SLOT_TICKS;
            guard_ticks_reg  <= RST_GUARD_TICKS;
            period_ticks_reg <= RST_PERIOD_TICKS;
        end
        else
        begin
            state_reg     <= state_next;
            seen_reg      <= seen_next;
            origin_reg    <= origin_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_NODE_SLOT:    node_slot_reg    <= cfg_data[SLOT_BITS-1:0];
                    CFG_NUM_SLOTS:    num_slots_reg    <= cfg_data[NSLOT_BITS-1:0];
                    CFG_SLOT_TICKS:   slot_ticks_reg   <= cfg_data;
                    CFG_GUARD_TICKS:  guard_ticks_reg  <= cfg_data;
                    CFG_PERIOD_TICKS: period_ticks_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        now_reg    <= now_next;
        d_reg      <= d_next;
        start_reg  <= start_next;
        limit_reg  <= limit_next;
        status_reg <= status_next;
        delay_reg  <= delay_next;
        res_reg    <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // only a delayed send carries a nonzero delay
    a_delay_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.status == ST_SEND_DELAY || res.delay == '0))
        else $error("nonzero delay on a result without delay");

    // a latched beacon always leaves the beacon flag set
    a_latch_seen: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status == ST_LATCHED) |-> seen_reg)
        else $error("beacon latched but flag clear");

    // after folding, elapsed time never exceeds one period
    a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL) |-> (d_x <= per_x))
        else $error("elapsed time beyond one period at evaluation");

    // the divider only finishes while the sequencer waits for it
    a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside its wait state");

endmodule

`default_nettype wire

[dv/tdma_slot_transmit_scheduler_top_tb.sv]
`timescale 1ns / 100ps

module tdma_slot_transmit_scheduler_top_tb;

    import tdmas_pkg::*;

    // event kinds on the evt channel
    localparam logic MODE_BEACON = 1'b0;
    localparam logic MODE_SEND   = 1'b1;

    // timer arithmetic wraps at the default timer width
    localparam logic [63:0] TIME_MASK = (64'd1 << TIME_BITS_DEF) - 64'd1;

    // run limits
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int RANDOM_PHASES  = 12;
    localparam int EVTS_PER_PHASE = 104;
    localparam int LONG_HOLD      = 400;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    evt_valid = 1'b0;
    logic                    evt_stall;
    evt_item_t               evt       = '0;
    logic                    res_valid;
    logic                    res_stall = 1'b0;
    res_item_t               res;
    logic                    cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = CFG_NODE_SLOT;
    logic [TICK_BITS-1:0]    cfg_data  = '0;

    // events waiting to be offered, and schedule results owed by the block
    evt_item_t pending_evts[$];
    res_item_t due_results[$];

    // scheduler image: register copies and timing state, 64 bits wide for headroom
    logic [63:0] sch_node_slot    = 64'd1;
    logic [63:0] sch_num_slots    = 64'd3;
    logic [63:0] sch_slot_ticks   = 64'd10922;
    logic [63:0] sch_guard_ticks  = 64'd2730;
    logic [63:0] sch_period_ticks = 64'd32768;
    logic [63:0] sch_origin       = 64'd0;
    logic        sch_beacon_seen  = 1'b0;

    // bookkeeping
    int err_cnt        = 0;
    int evt_count      = 0;
    int res_count      = 0;
    int cfg_sets       = 0;
    int bp_cycles      = 0;
    int cycle_cnt      = 0;
    int status_tally[8];

    // sender burst shaping
    int burst_left = 1;
    int gap_left   = 0;

    // receiver stall pattern and the one long hold-off
    int rx_mode        = 0;
    int rx_span        = 0;
    int hold_left      = 0;
    bit long_hold_done = 1'b0;

    always #10 clk = ~clk;

    tdma_slot_transmit_scheduler_top u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // expected result of one event; updates origin and beacon flag
    function automatic res_item_t schedule_tx(input evt_item_t ev);
        res_item_t   r;
        logic [63:0] now_t;
        logic [63:0] per;
        logic [63:0] slot_len;
        logic [63:0] sid;
        logic [63:0] s_idx;
        logic [63:0] d;
        logic [63:0] sc;
        logic [63:0] slot_start;
        logic [63:0] slot_end;
        logic [63:0] tx_limit;
        logic [63:0] wait_t;
        r     = '0;
        now_t = {32'd0, ev.now} & TIME_MASK;
        if (ev.mode == MODE_BEACON)
        begin
            // only the first beacon sets the period origin
            if (!sch_beacon_seen)
            begin
                sch_origin      = now_t;
                sch_beacon_seen = 1'b1;
                r.status        = ST_LATCHED;
            end
            else
            begin
                r.status = ST_IGNORED;
            end
        end
        else if (sch_node_slot == sch_num_slots + 64'd1)
        begin
            // beacon node sends at once, beacon or not
            r.status = ST_BEACON_NODE;
        end
        else if (!sch_beacon_seen)
        begin
            r.status = ST_NO_BEACON;
        end
        else
        begin
            // zero lengths and slot zero fall back to one
            per      = (sch_period_ticks != 64'd0) ? sch_period_ticks : 64'd1;
            slot_len = (sch_slot_ticks != 64'd0) ? sch_slot_ticks : 64'd1;
            sid      = (sch_node_slot != 64'd0) ? sch_node_slot : 64'd1;
            s_idx    = sid - 64'd1;
            d        = (now_t - sch_origin) & TIME_MASK;
            // fold the origin forward by whole periods
            if (d > per)
            begin
                sch_origin = (sch_origin + (d / per) * per) & TIME_MASK;
                d          = (now_t - sch_origin) & TIME_MASK;
            end
            sc         = d / slot_len;
            slot_start = s_idx * slot_len;
            slot_end   = sid * slot_len;
            tx_limit   = (slot_end > sch_guard_ticks) ? slot_end - sch_guard_ticks : 64'd0;
            if (sc == s_idx && d < tx_limit)
            begin
                r.status = ST_SEND_NOW;
            end
            else
            begin
                // own slot still ahead in this period, or wait for the next one
                r.status = ST_SEND_DELAY;
                if (sc < s_idx)
                    wait_t = (slot_start - d) & TIME_MASK;
                else
                    wait_t = (per - d + slot_start) & TIME_MASK;
                r.delay = wait_t[TICK_BITS-1:0];
            end
        end
        return r;
    endfunction

    // driver: bursts of transfers with random gaps, payload held while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid <= 1'b0;
            evt       <= '0;
        end
        else
        begin
            if (evt_valid && evt_stall)
                bp_cycles++;
            if (evt_valid && !evt_stall)
            begin
                due_results.push_back(schedule_tx(evt));
                pending_evts.delete(0);
                evt_count++;
            end
            if (!(evt_valid && evt_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    evt_valid <= 1'b0;
                end
                else if (pending_evts.size() > 0)
                begin
                    evt_valid <= 1'b1;
                    evt       <= pending_evts[0];
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        // next burst: now and then a long one with no gaps at all
                        if ($urandom_range(0, 9) == 0)
                        begin
                            burst_left = $urandom_range(60, 200);
                            gap_left   = 0;
                        end
                        else
                        begin
                            burst_left = $urandom_range(1, 24);
                            case ($urandom_range(0, 3))
                                0:       gap_left = 0;
                                1, 2:    gap_left = $urandom_range(1, 4);
                                default: gap_left = $urandom_range(5, 16);
                            endcase
                        end
                    end
                end
                else
                begin
                    evt_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result transfer, then pick the next stall value
    always @(posedge clk or negedge rst_n)
    begin
        res_item_t exp_res;
        if (!rst_n)
        begin
            res_stall <= 1'b0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                res_count++;
                if (due_results.size() == 0)
                begin
                    $error("result with no event outstanding: status %0d delay %0d",
                           res.status, res.delay);
                    err_cnt++;
                end
                else
                begin
                    exp_res = due_results.pop_front();
                    status_tally[exp_res.status]++;
                    if (res.status !== exp_res.status)
                    begin
                        $error("status mismatch: expected %0d actual %0d",
                               exp_res.status, res.status);
                        err_cnt++;
                    end
                    if (res.delay !== exp_res.delay)
                    begin
                        $error("delay mismatch: expected %0d actual %0d",
                               exp_res.delay, res.delay);
                        err_cnt++;
                    end
                end
            end
            // stall pattern drifts between none, light, half and heavy
            if (rx_span == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_span = $urandom_range(20, 150);
            end
            else
            begin
                rx_span--;
            end
            // one long hold-off while the sender still has plenty queued
            if (!long_hold_done && res_count >= 200 && pending_evts.size() > 30)
            begin
                hold_left      = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else
            begin
                case (rx_mode)
                    0:       res_stall <= 1'b0;
                    1:       res_stall <= ($urandom_range(0, 7) == 0);
                    2:       res_stall <= ($urandom_range(0, 1) == 0);
                    default: res_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, due_results.size());
            $display("simulation failed");
            $finish;
        end
    end

    task automatic queue_evt(input logic mode, input logic [TICK_BITS-1:0] now_t);
        evt_item_t ev;
        ev.mode = mode;
        ev.now  = now_t;
        pending_evts.push_back(ev);
    endtask

    // all five registers, one per cycle, then the image follows
    task automatic write_config(input logic [SLOT_BITS-1:0] node,
                                input logic [NSLOT_BITS-1:0] ns,
                                input logic [TICK_BITS-1:0] slot_len,
                                input logic [TICK_BITS-1:0] guard,
                                input logic [TICK_BITS-1:0] per);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_NODE_SLOT;
        cfg_data  <= TICK_BITS'(node);
        @(posedge clk);
        cfg_index <= CFG_NUM_SLOTS;
        cfg_data  <= TICK_BITS'(ns);
        @(posedge clk);
        cfg_index <= CFG_SLOT_TICKS;
        cfg_data  <= slot_len;
        @(posedge clk);
        cfg_index <= CFG_GUARD_TICKS;
        cfg_data  <= guard;
        @(posedge clk);
        cfg_index <= CFG_PERIOD_TICKS;
        cfg_data  <= per;
        @(posedge clk);
        cfg_we <= 1'b0;
        sch_node_slot    = 64'(node);
        sch_num_slots    = 64'(ns);
        sch_slot_ticks   = 64'(slot_len);
        sch_guard_ticks  = 64'(guard);
        sch_period_ticks = 64'(per);
        cfg_sets++;
    endtask

    // sender pause: everything offered, accepted and answered
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_evts.size() != 0 || evt_valid || due_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // coherent settings most of the time, odd ones now and then
    task automatic random_config();
        logic [NSLOT_BITS-1:0] ns;
        logic [SLOT_BITS-1:0]  node;
        logic [TICK_BITS-1:0]  slot_len;
        logic [TICK_BITS-1:0]  guard;
        logic [TICK_BITS-1:0]  per;
        logic [63:0]           span;
        ns = NSLOT_BITS'($urandom_range(1, 15));
        case ($urandom_range(0, 5))
            0:       slot_len = $urandom_range(1, 8);
            1, 2:    slot_len = $urandom_range(9, 500);
            3:       slot_len = $urandom_range(501, 200000);
            4:       slot_len = $urandom;
            default: slot_len = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'd0;
        endcase
        span = {60'd0, ns} * {32'd0, slot_len};
        case ($urandom_range(0, 4))
            0, 1, 2:
            begin
                span = span + ({32'd0, $urandom} % ({32'd0, slot_len} + 64'd1));
                per  = (span[63:32] == 32'd0) ? span[31:0] : $urandom;
            end
            3:       per = $urandom_range(1, 1000);
            default: per = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'd0;
        endcase
        case ($urandom_range(0, 5))
            0, 1, 2:
            begin
                span  = {32'd0, $urandom} % ({32'd0, slot_len} + 64'd1);
                guard = span[31:0];
            end
            3:       guard = 32'd0;
            4:       guard = $urandom;
            default: guard = 32'hFFFF_FFFF;
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: node = SLOT_BITS'($urandom_range(1, ns));
            6:                node = SLOT_BITS'(ns) + 5'd1;
            7:                node = 5'd0;
            default:          node = SLOT_BITS'($urandom_range(ns + 2, 31));
        endcase
        write_config(node, ns, slot_len, guard, per);
    endtask

    // mostly requests aimed at the period grid around the own slot
    task automatic queue_random_events(input int count);
        logic [63:0] per;
        logic [63:0] slot_len;
        logic [63:0] sid;
        logic [63:0] k;
        logic [63:0] off;
        logic [63:0] t;
        per      = (sch_period_ticks != 64'd0) ? sch_period_ticks : 64'd1;
        slot_len = (sch_slot_ticks != 64'd0) ? sch_slot_ticks : 64'd1;
        sid      = (sch_node_slot != 64'd0) ? sch_node_slot : 64'd1;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 19))
                0: queue_evt(MODE_BEACON, $urandom);
                1: queue_evt(MODE_SEND, $urandom);
                default:
                begin
                    if ($urandom_range(0, 7) == 0)
                        k = {32'd0, $urandom_range(0, 5000)};
                    else
                        k = {32'd0, $urandom_range(0, 3)};
                    case ($urandom_range(0, 3))
                        0:
                            off = {32'd0, $urandom} % per;
                        1:
                            off = sid * slot_len - sch_guard_ticks
                                  + {32'd0, $urandom_range(0, 2)} - 64'd1;
                        default:
                            off = (sid - 64'd1) * slot_len
                                  + ({32'd0, $urandom} % (slot_len + 64'd2)) - 64'd1;
                    endcase
                    t = sch_origin + k * per + off;
                    queue_evt(MODE_SEND, t[TICK_BITS-1:0]);
                end
            endcase
        end
    endtask

    // stimulus sequence
    initial
    begin
        logic [63:0] org;
        foreach (status_tally[i])
            status_tally[i] = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset settings, no beacon yet: requests are refused
        queue_evt(MODE_SEND, 32'd0);
        queue_evt(MODE_SEND, 32'hFFFF_FFFF);
        wait_idle();

        // beacon node before any beacon, largest and smallest slot counts
        write_config(5'd16, 4'd15, 32'd1, 32'd0, 32'd1);
        queue_evt(MODE_SEND, 32'h0000_1234);
        wait_idle();
        write_config(5'd2, 4'd1, 32'd0, 32'd0, 32'd0);
        queue_evt(MODE_SEND, 32'hA5A5_5A5A);
        wait_idle();

        // default-like frame: latch, ignore, then the slot cases
        write_config(5'd1, 4'd3, 32'd10922, 32'd2730, 32'd32768);
        queue_evt(MODE_BEACON, 32'd1000);
        queue_evt(MODE_BEACON, 32'd5);
        queue_evt(MODE_SEND, 32'd1100);
        queue_evt(MODE_SEND, 32'd1000 + 32'd8191);
        queue_evt(MODE_SEND, 32'd1000 + 32'd8192);
        queue_evt(MODE_SEND, 32'd1000 + 32'd20000);
        // exactly one period on: no fold, zero delay
        queue_evt(MODE_SEND, 32'd1000 + 32'd32768);
        queue_evt(MODE_SEND, 32'd1000 + 32'd32769);
        // timer behind the origin wraps to a huge difference
        queue_evt(MODE_SEND, 32'd999);
        wait_idle();

        // later slot: wait within the period, inside the slot, inside the guard
        write_config(5'd2, 4'd3, 32'd100, 32'd10, 32'd1000);
        org = sch_origin;
        queue_evt(MODE_SEND, org[31:0] + 32'd5);
        queue_evt(MODE_SEND, org[31:0] + 32'd150);
        queue_evt(MODE_SEND, org[31:0] + 32'd195);
        wait_idle();

        // zero node slot, slot length and period
        write_config(5'd0, 4'd3, 32'd0, 32'd0, 32'd0);
        org = sch_origin;
        queue_evt(MODE_SEND, org[31:0] + 32'd7);
        wait_idle();

        // slot past the period end, guard longer than the slot end
        write_config(5'd31, 4'd3, 32'd100, 32'd5000, 32'd1000);
        org = sch_origin;
        queue_evt(MODE_SEND, org[31:0] + 32'd40);
        queue_evt(MODE_SEND, org[31:0] + 32'd3050);
        wait_idle();

        // random phases, the two extreme settings first
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 0)
                write_config(5'd0, 4'd0, 32'd0, 32'd0, 32'd0);
            else if (p == 1)
                write_config(5'd31, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            else
                random_config();
            queue_random_events(EVTS_PER_PHASE);
            wait_idle();
        end

        // tail: let any stray result show up
        repeat (60) @(posedge clk);
        $display("%0d events over %0d register settings, %0d input back-pressure cycles",
                 evt_count, cfg_sets, bp_cycles);
        $display("latched %0d ignored %0d refused %0d beacon node %0d now %0d delayed %0d",
                 status_tally[ST_LATCHED], status_tally[ST_IGNORED],
                 status_tally[ST_NO_BEACON], status_tally[ST_BEACON_NODE],
                 status_tally[ST_SEND_NOW], status_tally[ST_SEND_DELAY]);
        if (err_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
